// ----- rtl/fht_pkg.sv -----
// file handle table package: transaction structs, operation codes, queue entry type
// no dependencies
package fht_pkg;

	typedef enum logic [2:0] {
		OP_STORE   = 3'd0,
		OP_LOOKUP  = 3'd1,
		OP_LOOKUPM = 3'd2,
		OP_RELEASE = 3'd3,
		OP_ERASE   = 3'd4
	} op_t;

	localparam logic [1:0] MODE_RW = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] slot_index;
		logic [31:0] node_id;
		logic [1:0]  open_mode;
		logic [31:0] backing_fd;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [9:0]  result_index;
		logic [31:0] entry_node;
		logic [1:0]  entry_mode;
		logic [31:0] entry_fd;
		logic [10:0] erased_count;
		logic [10:0] open_count;
	} rsp_t;

	// classified command handed from front to back
	typedef struct packed {
		logic        valid_op;
		logic        in_range;
		logic [2:0]  kind;
		logic [31:0] slot_index;
		logic [31:0] node_id;
		logic [1:0]  open_mode;
		logic [31:0] backing_fd;
	} cmd_t;

endpackage

// ----- rtl/fht_front.sv -----
// front end: accepts request transactions, classifies them, two-entry command queue
// depends on fht_pkg
module fht_front #(
	parameter int CAPACITY = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fht_pkg::req_t  req,
	input  logic           push,
	output logic           full,
	output fht_pkg::cmd_t  cmd,
	output logic           cmd_valid,
	input  logic           cmd_take
);
	import fht_pkg::*;

	cmd_t       q_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	cmd_t       c;
	logic       do_push, do_pop;

	always_comb begin
		c.valid_op   = (req.kind <= 3'(OP_ERASE));
		c.in_range   = ({1'b0, req.slot_index} < 33'(CAPACITY));
		c.kind       = req.kind;
		c.slot_index = req.slot_index;
		c.node_id    = req.node_id;
		c.open_mode  = req.open_mode;
		c.backing_fd = req.backing_fd;
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) q_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

// ----- rtl/fht_back.sv -----
// back end: slot memories, clearing pass, sweeps for store and erase, result register
// depends on fht_pkg
module fht_back #(
	parameter int CAPACITY = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fht_pkg::cmd_t  cmd,
	input  logic           cmd_valid,
	output logic           cmd_take,
	output fht_pkg::rsp_t  rsp,
	output logic           empty,
	input  logic           pop
);
	import fht_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_SWEEP, S_READ, S_DONE
	} state_t;

	logic [31:0] node_mem [CAPACITY];
	logic [1:0]  mode_mem [CAPACITY];
	logic [31:0] fd_mem   [CAPACITY];

	state_t       state_q;
	cmd_t         cmd_q;
	logic [AW:0]  addr_q;
	logic [AW:0]  rdaddr_q;
	logic [31:0]  rnode_q, rfd_q;
	logic [1:0]   rmode_q;
	logic [CW-1:0] open_q, freed_q;
	logic         wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]  wr_node, wr_fd;
	logic [1:0]   wr_mode;
	logic         wr_node_only;
	rsp_t         rsp_q;
	rsp_t         rsp_init;
	logic         full_q;
	logic         rd_ok_q;

	assign rsp   = rsp_q;
	assign empty = !full_q;

	// erase of no node succeeds at once with nothing freed
	always_comb begin
		rsp_init    = '0;
		rsp_init.ok = (cmd.kind == 3'(OP_ERASE)) && (cmd.node_id == '0);
	end

	// read port: address registered, data registered
	always_ff @(posedge clk) begin
		rnode_q <= node_mem[rdaddr_q[AW-1:0]];
		rmode_q <= mode_mem[rdaddr_q[AW-1:0]];
		rfd_q   <= fd_mem[rdaddr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem[wr_addr] <= wr_node;
			if (!wr_node_only) begin
				mode_mem[wr_addr] <= wr_mode;
				fd_mem[wr_addr]   <= wr_fd;
			end
		end
	end

	// rd_ok_q: data at rnode_q corresponds to addr_q
	always_comb begin
		wr_en = 1'b0;
		wr_addr = addr_q[AW-1:0];
		wr_node = '0;
		wr_mode = '0;
		wr_fd = '0;
		wr_node_only = 1'b0;
		unique case (state_q)
			S_CLEAR: wr_en = 1'b1;
			S_SWEEP: begin
				if (rd_ok_q && !addr_q[AW]) begin
					if (cmd_q.kind == 3'(OP_STORE) && rnode_q == '0) begin
						wr_en = 1'b1;
						wr_node = cmd_q.node_id;
						wr_mode = cmd_q.open_mode;
						wr_fd = cmd_q.backing_fd;
					end else if (cmd_q.kind == 3'(OP_ERASE) && rnode_q == cmd_q.node_id) begin
						wr_en = 1'b1;
						wr_node_only = 1'b1;
					end
				end
			end
			S_READ: begin
				if (rd_ok_q && cmd_q.kind == 3'(OP_RELEASE)) wr_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			addr_q   <= '0;
			rdaddr_q <= '0;
			rd_ok_q  <= 1'b0;
			open_q   <= '0;
			freed_q  <= '0;
			full_q   <= 1'b0;
			cmd_q    <= '0;
			rsp_q    <= '0;
		end else begin
			if (pop && full_q) full_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == (AW+1)'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
					addr_q <= addr_q + 1'b1;
				end
				S_IDLE: begin
					if (cmd_valid && !(full_q && !pop)) begin
						cmd_q   <= cmd;
						rd_ok_q <= 1'b0;
						freed_q <= '0;
						addr_q  <= '0;
						rsp_q   <= rsp_init;
						if (!cmd.valid_op) begin
							state_q <= S_DONE;
						end else if (cmd.kind == 3'(OP_STORE) || cmd.kind == 3'(OP_ERASE)) begin
							if (cmd.kind == 3'(OP_ERASE) && cmd.node_id == '0)
								state_q <= S_DONE;
							else
								state_q <= S_SWEEP;
							rdaddr_q <= '0;
						end else if (!cmd.in_range) begin
							state_q <= S_DONE;
						end else begin
							rdaddr_q <= {1'b0, cmd.slot_index[AW-1:0]};
							state_q <= S_READ;
						end
					end
				end
				S_SWEEP: begin
					rd_ok_q <= 1'b1;
					if (rd_ok_q) begin
						if (addr_q[AW]) begin
							if (cmd_q.kind == 3'(OP_ERASE)) begin
								rsp_q.ok <= 1'b1;
								rsp_q.erased_count <= 11'(freed_q);
								open_q <= open_q - freed_q;
							end
							state_q <= S_DONE;
						end else if (cmd_q.kind == 3'(OP_STORE) && rnode_q == '0) begin
							rsp_q.ok <= 1'b1;
							rsp_q.result_index <= 10'(addr_q[AW-1:0]);
							if (cmd_q.node_id != '0) open_q <= open_q + 1'b1;
							state_q <= S_DONE;
						end else begin
							if (cmd_q.kind == 3'(OP_ERASE) && rnode_q == cmd_q.node_id)
								freed_q <= freed_q + 1'b1;
							if (addr_q == (AW+1)'(CAPACITY - 1))
								addr_q <= {1'b1, {AW{1'b0}}};
							else
								addr_q <= addr_q + 1'b1;
							rdaddr_q <= rdaddr_q + 1'b1;
							rd_ok_q <= 1'b0;
						end
					end else begin
						rdaddr_q <= addr_q;
					end
				end
				S_READ: begin
					rd_ok_q <= 1'b1;
					addr_q <= rdaddr_q;
					if (rd_ok_q) begin
						state_q <= S_DONE;
						if (cmd_q.kind == 3'(OP_LOOKUPM)) begin
							if (rnode_q != '0 && (rmode_q == cmd_q.open_mode || rmode_q == MODE_RW)) begin
								rsp_q.ok <= 1'b1;
								rsp_q.entry_node <= rnode_q;
								rsp_q.entry_mode <= rmode_q;
								rsp_q.entry_fd <= rfd_q;
							end
						end else begin
							rsp_q.ok <= 1'b1;
							rsp_q.entry_node <= rnode_q;
							rsp_q.entry_mode <= rmode_q;
							rsp_q.entry_fd <= rfd_q;
							if (cmd_q.kind == 3'(OP_RELEASE) && rnode_q != '0)
								open_q <= open_q - 1'b1;
						end
					end
				end
				S_DONE: begin
					rsp_q.open_count <= 11'(open_q);
					full_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_take = (state_q == S_IDLE) && cmd_valid && !(full_q && !pop);
endmodule

// ----- rtl/file_handle_table.sv -----
// file handle table top level: joins front classifier and back executor
// depends on fht_pkg, fht_front, fht_back
//
// channel  | handshake         | payload
// request  | push / full       | req  (fht_pkg::req_t)
// result   | pop / empty       | rsp  (fht_pkg::rsp_t)
//
// lookup, mode lookup and release read the addressed slot once; store and erase sweep
// the slot memory, one slot at a time, through its registered read port
// after reset a clearing pass writes every slot before any request runs
// a two-entry queue takes requests while the back end works or the result waits
module file_handle_table #(
	parameter int CAPACITY = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fht_pkg::req_t  req,
	input  logic           push,
	output logic           full,
	output fht_pkg::rsp_t  rsp,
	output logic           empty,
	input  logic           pop
);
	import fht_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_take;

	fht_front #(.CAPACITY(CAPACITY)) u_front (
		.clk(clk), .arst_n(arst_n), .req(req), .push(push), .full(full),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
	);

	fht_back #(.CAPACITY(CAPACITY)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_take(cmd_take), .rsp(rsp), .empty(empty), .pop(pop)
	);
endmodule
